>>> rtl/i2cmts_pkg.sv
// Shared types and codes for the I2C master transfer sequencer.
// No dependencies; imported by every module of the block.
package i2cmts_pkg;

  localparam int unsigned DEF_INDEX_BITS = 10;
  localparam int unsigned OUT_INDEX_BITS = 10;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_EVENT = 1'b1;

  // TWI status codes, prescaler bits already masked
  localparam logic [7:0] BS_START      = 8'h08;
  localparam logic [7:0] BS_RSTART     = 8'h10;
  localparam logic [7:0] BS_SLAW_ACK   = 8'h18;
  localparam logic [7:0] BS_SLAW_NACK  = 8'h20;
  localparam logic [7:0] BS_DATA_ACK   = 8'h28;
  localparam logic [7:0] BS_DATA_NACK  = 8'h30;
  localparam logic [7:0] BS_SLAR_ACK   = 8'h40;
  localparam logic [7:0] BS_RDATA_ACK  = 8'h50;
  localparam logic [7:0] BS_RDATA_NACK = 8'h58;
  localparam logic [7:0] BS_SLAVE_STOP = 8'hA0;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_START   = 3'd1,
    ACT_STOP    = 3'd2,
    ACT_ACK     = 3'd3,
    ACT_NACK    = 3'd4,
    ACT_RELEASE = 3'd5,
    ACT_CLEAR   = 3'd6
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_REPLY  = 2'd1,
    ST_DATA_NACK = 2'd2
  } status_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] write_len;
    logic [7:0] read_len;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       busy;
    logic [7:0] writes_left;
    logic [7:0] reads_left;
  } ctr_t;

  typedef struct packed {
    action_e                   action;
    logic                      tx_valid;
    logic [OUT_INDEX_BITS-1:0] tx_index;
    logic                      store_valid;
    logic [OUT_INDEX_BITS-1:0] store_index;
    logic [7:0]                store_data;
    logic                      status_valid;
    status_e                   status_code;
    logic                      busy_res;
  } result_t;

endpackage

>>> rtl/i2cmts_step.sv
// Next-state and result logic for one word of the sequencer.
// Depends on i2cmts_pkg.
module i2cmts_step
  import i2cmts_pkg::*;
#(
  parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
  input  item_t                 item_i,
  input  ctr_t                  cnt_i,
  input  logic [INDEX_BITS-1:0] ptr_i,
  output ctr_t                  cnt_o,
  output logic [INDEX_BITS-1:0] ptr_o,
  output result_t               res_o
);

  localparam int unsigned EXT_W = INDEX_BITS + OUT_INDEX_BITS;

  logic [INDEX_BITS-1:0] ptr_inc;
  logic [EXT_W-1:0]      ptr_ext;
  logic [EXT_W-1:0]      inc_ext;
  logic [7:0]            reads_dec;
  logic                  stop;
  status_e               code;

  assign ptr_inc   = ptr_i + INDEX_BITS'(1);
  assign ptr_ext   = {{OUT_INDEX_BITS{1'b0}}, ptr_i};
  assign inc_ext   = {{OUT_INDEX_BITS{1'b0}}, ptr_inc};
  // read counter saturates at zero
  assign reads_dec = (cnt_i.reads_left != 8'd0) ? cnt_i.reads_left - 8'd1 : 8'd0;

  always_comb begin
    cnt_o = cnt_i;
    ptr_o = ptr_i;
    res_o = '0;
    res_o.action      = ACT_NONE;
    res_o.status_code = ST_DONE;
    stop = 1'b0;
    code = ST_DONE;

    if (item_i.cmd == CMD_START) begin
      if (!cnt_i.busy) begin
        cnt_o.busy        = 1'b1;
        cnt_o.writes_left = item_i.write_len;
        cnt_o.reads_left  = item_i.read_len;
        ptr_o             = INDEX_BITS'(2);
        res_o.action      = ACT_START;
      end
    end else begin
      unique case (item_i.bus_status) inside
        BS_START, BS_RSTART: begin
          ptr_o          = ptr_inc;
          res_o.tx_valid = 1'b1;
          res_o.tx_index = inc_ext[OUT_INDEX_BITS-1:0];
          res_o.action   = ACT_ACK;
        end
        BS_SLAW_NACK: begin
          stop = 1'b1;
          code = ST_NO_REPLY;
        end
        BS_DATA_NACK: begin
          stop = 1'b1;
          code = ST_DATA_NACK;
        end
        BS_SLAW_ACK, BS_DATA_ACK: begin
          if (cnt_i.writes_left != 8'd0) begin
            cnt_o.writes_left = cnt_i.writes_left - 8'd1;
            ptr_o             = ptr_inc;
            res_o.tx_valid    = 1'b1;
            res_o.tx_index    = inc_ext[OUT_INDEX_BITS-1:0];
            res_o.action      = ACT_ACK;
          end else if (cnt_i.reads_left == 8'd0) begin
            stop = 1'b1;
          end else begin
            res_o.action = ACT_START;  // repeated start for the read phase
          end
        end
        BS_SLAR_ACK, BS_RDATA_ACK: begin
          if (item_i.bus_status == BS_RDATA_ACK) begin
            res_o.store_valid = 1'b1;
            res_o.store_index = ptr_ext[OUT_INDEX_BITS-1:0];
            res_o.store_data  = item_i.rx_byte;
          end
          cnt_o.reads_left = reads_dec;
          ptr_o            = ptr_inc;
          res_o.action     = (reads_dec != 8'd0) ? ACT_ACK : ACT_NACK;
        end
        BS_RDATA_NACK: begin
          res_o.store_valid = 1'b1;
          res_o.store_index = ptr_ext[OUT_INDEX_BITS-1:0];
          res_o.store_data  = item_i.rx_byte;
          stop = 1'b1;
        end
        BS_SLAVE_STOP: res_o.action = ACT_RELEASE;
        default:       res_o.action = ACT_CLEAR;
      endcase

      if (stop) begin
        res_o.action       = ACT_STOP;
        res_o.status_valid = 1'b1;
        res_o.status_code  = code;
        cnt_o.busy         = 1'b0;
      end
    end

    res_o.busy_res = cnt_o.busy;
  end

endmodule

>>> rtl/i2c_master_transfer_sequencer.sv
// I2C master write-then-read transfer sequencer: one result word per input word,
// one word per cycle sustained while the consumer keeps up. A word is captured in the
// input register, decoded against the counters and buffer pointer in a single
// pass, and the result lands in the output register. Both registers stall in
// place when the consumer holds off, so the input side keeps taking words until
// both stages are full. A start request while busy yields action none; the
// buffer pointer starts at index 2 and wraps at 2^INDEX_BITS.
// Depends on i2cmts_pkg and i2cmts_step.
module i2c_master_transfer_sequencer
  import i2cmts_pkg::*;
#(
  parameter int unsigned INDEX_BITS = DEF_INDEX_BITS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [7:0]                write_len_i,
  input  logic [7:0]                read_len_i,
  input  logic [7:0]                bus_status_i,
  input  logic [7:0]                rx_byte_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [2:0]                action_o,
  output logic                      tx_valid_o,
  output logic [OUT_INDEX_BITS-1:0] tx_index_o,
  output logic                      store_valid_o,
  output logic [OUT_INDEX_BITS-1:0] store_index_o,
  output logic [7:0]                store_data_o,
  output logic                      status_valid_o,
  output logic [1:0]                status_code_o,
  output logic                      busy_res_o
);

  logic                  in_vld_q;
  item_t                 item_q;
  logic                  out_vld_q;
  result_t               res_q;
  result_t               res_d;
  ctr_t                  cnt_q, cnt_d;
  logic [INDEX_BITS-1:0] ptr_q, ptr_d;
  logic                  advance;

  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{cmd: cmd_i, write_len: write_len_i, read_len: read_len_i,
                  bus_status: bus_status_i, rx_byte: rx_byte_i};
    end
  end

  i2cmts_step #(
    .INDEX_BITS (INDEX_BITS)
  ) u_step (
    .item_i (item_q),
    .cnt_i  (cnt_q),
    .ptr_i  (ptr_q),
    .cnt_o  (cnt_d),
    .ptr_o  (ptr_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      ptr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        cnt_q <= cnt_d;
        ptr_q <= ptr_d;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign action_o       = res_q.action;
  assign tx_valid_o     = res_q.tx_valid;
  assign tx_index_o     = res_q.tx_index;
  assign store_valid_o  = res_q.store_valid;
  assign store_index_o  = res_q.store_index;
  assign store_data_o   = res_q.store_data;
  assign status_valid_o = res_q.status_valid;
  assign status_code_o  = res_q.status_code;
  assign busy_res_o     = res_q.busy_res;

endmodule

>>> rtl/i2cmts_checker.sv
// Port-level checks for the I2C master transfer sequencer, bound to the top.
// Depends on i2cmts_pkg and i2c_master_transfer_sequencer.
module i2cmts_checker
  import i2cmts_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [2:0]                action_o,
  input logic                      tx_valid_o,
  input logic [OUT_INDEX_BITS-1:0] tx_index_o,
  input logic                      store_valid_o,
  input logic [OUT_INDEX_BITS-1:0] store_index_o,
  input logic [7:0]                store_data_o,
  input logic                      status_valid_o,
  input logic                      busy_res_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(action_o) && $stable(busy_res_o))
    else $error("result word changed while stalled");

  // end of transfer always sends STOP and drops busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_valid_o |-> action_o == ACT_STOP && !busy_res_o)
    else $error("status reported without stop");

  // a byte to send always comes with a continue-ack; bus events also run while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tx_valid_o |-> action_o == ACT_ACK)
    else $error("tx byte without ack action");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o && !store_valid_o |->
      tx_index_o == '0 && store_index_o == '0 && store_data_o == 8'd0)
    else $error("index fields not cleared");

endmodule

bind i2c_master_transfer_sequencer i2cmts_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .action_o       (action_o),
  .tx_valid_o     (tx_valid_o),
  .tx_index_o     (tx_index_o),
  .store_valid_o  (store_valid_o),
  .store_index_o  (store_index_o),
  .store_data_o   (store_data_o),
  .status_valid_o (status_valid_o),
  .busy_res_o     (busy_res_o)
);

>>> tb/sv/tb_top.sv
// Self-checking testbench for the I2C master write-then-read transfer sequencer.
// Holds a scoreboard class that predicts each result word; depends on i2cmts_pkg
// and the i2c_master_transfer_sequencer RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmts_pkg::*;

  localparam int unsigned IDX_BITS = DEF_INDEX_BITS;

  localparam logic [7:0] KNOWN_CODES [10] = '{
    BS_START, BS_RSTART, BS_SLAW_ACK, BS_SLAW_NACK, BS_DATA_ACK,
    BS_DATA_NACK, BS_SLAR_ACK, BS_RDATA_ACK, BS_RDATA_NACK, BS_SLAVE_STOP
  };

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      cmd_i;
  logic [7:0]                write_len_i;
  logic [7:0]                read_len_i;
  logic [7:0]                bus_status_i;
  logic [7:0]                rx_byte_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [2:0]                action_o;
  logic                      tx_valid_o;
  logic [OUT_INDEX_BITS-1:0] tx_index_o;
  logic                      store_valid_o;
  logic [OUT_INDEX_BITS-1:0] store_index_o;
  logic [7:0]                store_data_o;
  logic                      status_valid_o;
  logic [1:0]                status_code_o;
  logic                      busy_res_o;

  // Tracks the sequencer state and the words it owes us
  class transfer_scoreboard;
    bit                  busy = 1'b0;
    logic [7:0]          wr_left = '0;
    logic [7:0]          rd_left = '0;
    logic [IDX_BITS-1:0] ptr = '0;
    result_t             due[$];
    int                  errors = 0;

    function void take_word(item_t w);
      result_t r;
      bit      halt;
      r = '0;
      r.action = ACT_NONE;
      r.status_code = ST_DONE;
      halt = 1'b0;
      if (w.cmd == CMD_START) begin
        if (!busy) begin
          wr_left = w.write_len;
          rd_left = w.read_len;
          ptr = IDX_BITS'(2);
          busy = 1'b1;
          r.action = ACT_START;
        end
      end else begin
        case (w.bus_status)
          BS_START, BS_RSTART: begin
            ptr = ptr + IDX_BITS'(1);
            r.tx_valid = 1'b1;
            r.tx_index = OUT_INDEX_BITS'(ptr);
            r.action = ACT_ACK;
          end
          BS_SLAW_NACK: begin
            halt = 1'b1;
            r.status_code = ST_NO_REPLY;
          end
          BS_DATA_NACK: begin
            halt = 1'b1;
            r.status_code = ST_DATA_NACK;
          end
          BS_SLAW_ACK, BS_DATA_ACK: begin
            if (wr_left != 8'd0) begin
              wr_left = wr_left - 8'd1;
              ptr = ptr + IDX_BITS'(1);
              r.tx_valid = 1'b1;
              r.tx_index = OUT_INDEX_BITS'(ptr);
              r.action = ACT_ACK;
            end else if (rd_left == 8'd0) begin
              halt = 1'b1;
            end else begin
              r.action = ACT_START;  // repeated start for the read phase
            end
          end
          BS_SLAR_ACK, BS_RDATA_ACK: begin
            if (w.bus_status == BS_RDATA_ACK) begin
              r.store_valid = 1'b1;
              r.store_index = OUT_INDEX_BITS'(ptr);
              r.store_data = w.rx_byte;
            end
            if (rd_left != 8'd0) rd_left = rd_left - 8'd1;
            ptr = ptr + IDX_BITS'(1);
            r.action = (rd_left != 8'd0) ? ACT_ACK : ACT_NACK;
          end
          BS_RDATA_NACK: begin
            r.store_valid = 1'b1;
            r.store_index = OUT_INDEX_BITS'(ptr);
            r.store_data = w.rx_byte;
            halt = 1'b1;
          end
          BS_SLAVE_STOP: r.action = ACT_RELEASE;
          default:       r.action = ACT_CLEAR;
        endcase
        if (halt) begin
          r.action = ACT_STOP;
          busy = 1'b0;
          r.status_valid = 1'b1;
        end
      end
      r.busy_res = busy;
      due.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      bit      bad;
      if (due.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
        return;
      end
      want = due.pop_front();
      bad = 1'b0;
      if (got.action !== want.action) begin
        $error("action: expected %0d, got %0d", want.action, got.action);
        bad = 1'b1;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $error("tx_valid: expected %0d, got %0d", want.tx_valid, got.tx_valid);
        bad = 1'b1;
      end
      if (got.tx_index !== want.tx_index) begin
        $error("tx_index: expected %0d, got %0d", want.tx_index, got.tx_index);
        bad = 1'b1;
      end
      if (got.store_valid !== want.store_valid) begin
        $error("store_valid: expected %0d, got %0d", want.store_valid, got.store_valid);
        bad = 1'b1;
      end
      if (got.store_index !== want.store_index) begin
        $error("store_index: expected %0d, got %0d", want.store_index, got.store_index);
        bad = 1'b1;
      end
      if (got.store_data !== want.store_data) begin
        $error("store_data: expected %0d, got %0d", want.store_data, got.store_data);
        bad = 1'b1;
      end
      if (got.status_valid !== want.status_valid) begin
        $error("status_valid: expected %0d, got %0d", want.status_valid, got.status_valid);
        bad = 1'b1;
      end
      if (got.status_code !== want.status_code) begin
        $error("status_code: expected %0d, got %0d", want.status_code, got.status_code);
        bad = 1'b1;
      end
      if (got.busy_res !== want.busy_res) begin
        $error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
        bad = 1'b1;
      end
      if (bad) errors++;
    endfunction
  endclass

  transfer_scoreboard board = new();

  int sent = 0;
  int calm_at = 32'h7fff_ffff;  // no idling once this many words went in
  bit src_gaps = 1'b1;

  i2c_master_transfer_sequencer #(
    .INDEX_BITS(IDX_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .cmd_i         (cmd_i),
    .write_len_i   (write_len_i),
    .read_len_i    (read_len_i),
    .bus_status_i  (bus_status_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .action_o      (action_o),
    .tx_valid_o    (tx_valid_o),
    .tx_index_o    (tx_index_o),
    .store_valid_o (store_valid_o),
    .store_index_o (store_index_o),
    .store_data_o  (store_data_o),
    .status_valid_o(status_valid_o),
    .status_code_o (status_code_o),
    .busy_res_o    (busy_res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Output side: random stall bursts, none near the end
  initial begin
    forever begin
      if (sent < calm_at && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : result_monitor
    result_t seen;
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen.action       = action_e'(action_o);
      seen.tx_valid     = tx_valid_o;
      seen.tx_index     = tx_index_o;
      seen.store_valid  = store_valid_o;
      seen.store_index  = store_index_o;
      seen.store_data   = store_data_o;
      seen.status_valid = status_valid_o;
      seen.status_code  = status_e'(status_code_o);
      seen.busy_res     = busy_res_o;
      board.match_result(seen);
    end
  end

  // Drive one word and hold it until taken; may drop valid for a burst after
  task automatic send_word(input logic c, input logic [7:0] wl, input logic [7:0] rl,
                           input logic [7:0] bs, input logic [7:0] rx);
    item_t w;
    w.cmd = c;
    w.write_len = wl;
    w.read_len = rl;
    w.bus_status = bs;
    w.rx_byte = rx;
    cmd_i <= c;
    write_len_i <= wl;
    read_len_i <= rl;
    bus_status_i <= bs;
    rx_byte_i <= rx;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.take_word(w);
    sent++;
    if (sent < calm_at && src_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic send_event(input logic [7:0] code);
    send_word(CMD_EVENT, 8'($urandom), 8'($urandom), code, 8'($urandom));
  endtask

  // Out-of-sequence word: start request, slave stop, or a random or known status code
  task automatic stray_word();
    case ($urandom_range(0, 3))
      0: send_word(CMD_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      1: send_event(BS_SLAVE_STOP);
      2: send_event(8'($urandom));
      default: send_event(KNOWN_CODES[$urandom_range(0, 9)]);
    endcase
  endtask

  // Well-formed write-then-read transfer, with the odd fault or stray word
  task automatic run_transfer(input logic [7:0] wl, input logic [7:0] rl);
    int k;
    send_word(CMD_START, wl, rl, 8'($urandom), 8'($urandom));
    send_event(BS_START);
    if ($urandom_range(0, 19) == 0) begin
      send_event(BS_SLAW_NACK);
      return;
    end
    send_event(BS_SLAW_ACK);
    for (k = 0; k < int'(wl); k++) begin
      if ($urandom_range(0, 39) == 0) stray_word();
      if ($urandom_range(0, 59) == 0) begin
        send_event(BS_DATA_NACK);
        return;
      end
      send_event(BS_DATA_ACK);
    end
    if (rl == 8'd0) return;
    send_event(BS_RSTART);
    send_event(BS_SLAR_ACK);
    for (k = 1; k < int'(rl); k++) begin
      if ($urandom_range(0, 39) == 0) stray_word();
      send_event(BS_RDATA_ACK);
    end
    send_event(BS_RDATA_NACK);
  endtask

  initial begin
    int goal;
    int big_at;
    int seq_no;
    int n;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    cmd_i <= CMD_START;
    write_len_i <= '0;
    read_len_i <= '0;
    bus_status_i <= '0;
    rx_byte_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: idle events, unknown codes, every path, count extremes
    send_event(BS_START);
    send_event(8'h09);
    send_event(8'h00);
    send_event(8'hFF);
    send_word(CMD_START, 8'd0, 8'd0, 8'h00, 8'h00);
    send_word(CMD_START, 8'd255, 8'd255, 8'hFF, 8'hFF);  // ignored, busy
    send_event(BS_START);
    send_event(BS_SLAW_ACK);                               // no bytes at all
    send_word(CMD_START, 8'd0, 8'd2, 8'h00, 8'h00);
    send_event(BS_START);
    send_event(BS_SLAW_ACK);                               // straight to read
    send_event(BS_RSTART);
    send_event(BS_SLAR_ACK);
    send_word(CMD_EVENT, 8'h00, 8'h00, BS_RDATA_ACK, 8'hFF);
    send_word(CMD_EVENT, 8'hFF, 8'hFF, BS_RDATA_ACK, 8'h00); // count already 0
    send_word(CMD_EVENT, 8'h00, 8'h00, BS_RDATA_NACK, 8'hA5);
    send_word(CMD_START, 8'd255, 8'd255, 8'h00, 8'h00);
    send_event(BS_START);
    send_event(BS_SLAW_ACK);
    send_event(BS_DATA_ACK);
    send_event(BS_SLAVE_STOP);
    send_event(BS_DATA_NACK);
    send_word(CMD_START, 8'd1, 8'd0, 8'h00, 8'h00);
    send_event(BS_SLAW_NACK);
    send_event(BS_RDATA_NACK);                             // not busy

    goal = sent + 1100;
    calm_at = sent + 1000;
    big_at = $urandom_range(2, 12);
    seq_no = 0;
    while (sent < goal) begin
      src_gaps = ($urandom_range(0, 3) != 0);
      if (seq_no == big_at) begin
        run_transfer(8'd255, 8'd255);
      end else if ($urandom_range(0, 4) != 0) begin
        run_transfer(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                                  : 8'($urandom_range(0, 6)),
                     ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 40))
                                                  : 8'($urandom_range(0, 6)));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) begin
          if ($urandom_range(0, 1) == 0) stray_word();
          else send_word(1'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom), 8'($urandom));
        end
      end
      seq_no++;
    end
    in_valid_i <= 1'b0;

    while (board.due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/i2cmts_pkg.sv
rtl/i2cmts_step.sv
rtl/i2c_master_transfer_sequencer.sv
rtl/i2cmts_checker.sv
tb/sv/tb_top.sv
